### src/mu8_pkg.sv
// ----------------------------------------------------------------------------
// mu8_pkg
// Shared types and constants of the modified UTF-8 decoder.
// ----------------------------------------------------------------------------
package mu8_pkg;

	// Sequence forms selected by the lead byte
	typedef enum logic [1:0] {
		FORM_ONE   = 2'd0,
		FORM_TWO   = 2'd1,
		FORM_THREE = 2'd2,
		FORM_SIX   = 2'd3
	} form_t;

	localparam logic [7:0]  LEAD_SIX       = 8'hED;
	localparam logic [7:0]  LEAD_THREE_MIN = 8'hE0;
	localparam logic [7:0]  LEAD_TWO_MIN   = 8'hC0;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;

	localparam logic [2:0]  LEN_ONE   = 3'd1;
	localparam logic [2:0]  LEN_TWO   = 3'd2;
	localparam logic [2:0]  LEN_THREE = 3'd3;
	localparam logic [2:0]  LEN_SIX   = 3'd6;

	// One decoded character
	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  bytes_used;
		logic [15:0] char_index;
		logic        incomplete;
		logic        last;
	} result_t;

endpackage

### src/mu8_in_if.sv
// ----------------------------------------------------------------------------
// mu8_in_if
// Byte channel: valid/ready handshake with one raw byte and an end mark.
// ----------------------------------------------------------------------------
interface mu8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       end_of_string;

	modport source (output valid, output byte_value, output end_of_string, input ready);
	modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

### src/mu8_out_if.sv
// ----------------------------------------------------------------------------
// mu8_out_if
// Character channel: valid/ready handshake with one decoded character.
// ----------------------------------------------------------------------------
interface mu8_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [2:0]  bytes_used;
	logic [15:0] char_index;
	logic        incomplete;
	logic        last;

	modport source (output valid, output code_point, output bytes_used,
		output char_index, output incomplete, output last, input ready);
	modport sink   (input valid, input code_point, input bytes_used,
		input char_index, input incomplete, input last, output ready);
endinterface

### src/mu8_core.sv
// ----------------------------------------------------------------------------
// mu8_core
// Sequence state and per-byte decode; builds a character when one completes or the string ends.
// ----------------------------------------------------------------------------
module mu8_core #(
	parameter int INDEX_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,      // staged byte present
	input  logic [7:0]       byte_value,
	input  logic             end_of_string,
	input  logic             advance,    // staged byte is consumed this cycle
	output logic             emit,       // staged byte completes a character or ends the string
	output mu8_pkg::result_t result
);

	logic [2:0]            pending_q;
	mu8_pkg::form_t        form_q;
	logic [20:0]           partial_q;
	logic [2:0]            pos_q;
	logic [INDEX_BITS-1:0] count_q;

	logic [2:0]            pending_d;
	mu8_pkg::form_t        form_d;
	logic [20:0]           partial_d;
	logic [2:0]            pos_d;
	logic [20:0]           cont_bits;
	logic                  done;
	logic [INDEX_BITS+15:0] index_ext;

	function automatic logic [2:0] form_length(mu8_pkg::form_t f);
		case (f)
			mu8_pkg::FORM_TWO:   form_length = mu8_pkg::LEN_TWO;
			mu8_pkg::FORM_THREE: form_length = mu8_pkg::LEN_THREE;
			mu8_pkg::FORM_SIX:   form_length = mu8_pkg::LEN_SIX;
			default:             form_length = mu8_pkg::LEN_ONE;
		endcase
	endfunction

	// payload of a continuation byte at its place in the sequence
	always_comb begin
		cont_bits = '0;
		case (form_q)
			mu8_pkg::FORM_SIX: begin
				case (pos_q)
					3'd1:    cont_bits = {1'b0, byte_value[3:0], 16'd0};
					3'd3:    cont_bits = {5'd0, byte_value[5:0], 10'd0};
					3'd4:    cont_bits = {11'd0, byte_value[3:0], 6'd0};
					3'd5:    cont_bits = {15'd0, byte_value[5:0]};
					default: cont_bits = '0;
				endcase
			end
			mu8_pkg::FORM_THREE: begin
				case (pos_q)
					3'd1:    cont_bits = {9'd0, byte_value[5:0], 6'd0};
					3'd2:    cont_bits = {15'd0, byte_value[5:0]};
					default: cont_bits = '0;
				endcase
			end
			mu8_pkg::FORM_TWO: begin
				if (pos_q == 3'd1) begin
					cont_bits = {15'd0, byte_value[5:0]};
				end
			end
			default: cont_bits = '0;
		endcase
	end

	always_comb begin
		if (pending_q == 3'd0) begin
			if (byte_value == mu8_pkg::LEAD_SIX) begin
				form_d    = mu8_pkg::FORM_SIX;
				partial_d = mu8_pkg::SUPP_BASE;
			end else if (byte_value >= mu8_pkg::LEAD_THREE_MIN) begin
				form_d    = mu8_pkg::FORM_THREE;
				partial_d = {5'd0, byte_value[3:0], 12'd0};
			end else if (byte_value >= mu8_pkg::LEAD_TWO_MIN) begin
				form_d    = mu8_pkg::FORM_TWO;
				partial_d = {10'd0, byte_value[4:0], 6'd0};
			end else begin
				form_d    = mu8_pkg::FORM_ONE;
				partial_d = {14'd0, byte_value[6:0]};
			end
			pending_d = form_length(form_d) - 3'd1;
			pos_d     = 3'd1;
		end else begin
			form_d    = form_q;
			partial_d = partial_q + cont_bits;
			pending_d = pending_q - 3'd1;
			pos_d     = pos_q + 3'd1;
		end
	end

	assign done      = (pending_d == 3'd0);
	assign emit      = valid && (done || end_of_string);
	assign index_ext = {16'd0, count_q};

	always_comb begin
		result.code_point = partial_d;
		result.bytes_used = form_length(form_d);
		result.char_index = index_ext[15:0];
		result.incomplete = !done && end_of_string;
		result.last       = end_of_string;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			form_q    <= mu8_pkg::FORM_ONE;
			partial_q <= '0;
			pos_q     <= '0;
			count_q   <= '0;
		end else if (advance) begin
			if (emit) begin
				pending_q <= '0;
				form_q    <= mu8_pkg::FORM_ONE;
				partial_q <= '0;
				pos_q     <= '0;
				if (end_of_string) begin
					count_q <= '0;
				end else if (count_q != {INDEX_BITS{1'b1}}) begin
					count_q <= count_q + 1'b1;
				end
			end else begin
				pending_q <= pending_d;
				form_q    <= form_d;
				partial_q <= partial_d;
				pos_q     <= pos_d;
			end
		end
	end

	// an open sequence never expects more than five more bytes
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd5)
		else $error("pending byte count out of range");

	// position and pending bytes always add up to the form length
	a_pos_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 3'd0 |-> (pos_q + pending_q) == form_length(form_q))
		else $error("sequence position and pending count disagree");

endmodule

### src/modified_utf8_decoder.sv
// ----------------------------------------------------------------------------
// modified_utf8_decoder
// Decodes a modified UTF-8 byte stream into one character per sequence.
// ----------------------------------------------------------------------------
// Path: a completing byte passes the input stage, then the result register,
//   before its character can be taken.
// Throughput: one byte per cycle, set by the single decode pass between the
//   input stage and the result register; stalls only on a held result.
// Reset (arst_n low, asynchronous): stages empty, no open sequence,
//   character index back to zero.
// ----------------------------------------------------------------------------
module modified_utf8_decoder #(
	parameter int INDEX_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	mu8_in_if.sink    byte_stream,
	mu8_out_if.source char_stream
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// result register
	logic             res_valid_q;
	mu8_pkg::result_t res_q;

	logic             emit;
	logic             advance;
	mu8_pkg::result_t result;

	// The staged byte moves on unless it makes a character and the result
	// register is still held by the sink. Bytes in mid-sequence never wait.
	assign advance = valid_s1 && (!emit || !res_valid_q || char_stream.ready);

	// Take a new byte when the stage is empty or emptying this cycle.
	assign byte_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			byte_s1 <= byte_stream.byte_value;
			eos_s1  <= byte_stream.end_of_string;
		end
	end

	mu8_core #(
		.INDEX_BITS(INDEX_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (valid_s1),
		.byte_value    (byte_s1),
		.end_of_string (eos_s1),
		.advance       (advance),
		.emit          (emit),
		.result        (result)
	);

	// Result register: loaded on each emitted character, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (char_stream.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= result;
		end
	end

	assign char_stream.valid      = res_valid_q;
	assign char_stream.code_point = res_q.code_point;
	assign char_stream.bytes_used = res_q.bytes_used;
	assign char_stream.char_index = res_q.char_index;
	assign char_stream.incomplete = res_q.incomplete;
	assign char_stream.last       = res_q.last;

	// a held byte blocks the input side
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !byte_stream.ready)
		else $error("input accepted while staged byte is held");

	// a truncated sequence always closes its string
	a_incomplete_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_stream.valid && char_stream.incomplete |-> char_stream.last)
		else $error("incomplete character not marked last");

	// only the four form lengths appear
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		char_stream.valid |-> (char_stream.bytes_used == mu8_pkg::LEN_ONE ||
			char_stream.bytes_used == mu8_pkg::LEN_TWO ||
			char_stream.bytes_used == mu8_pkg::LEN_THREE ||
			char_stream.bytes_used == mu8_pkg::LEN_SIX))
		else $error("illegal sequence length");

	// the first character after a string end starts again at index zero
	a_index_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && res_valid_q && res_q.last |=> res_q.char_index == 16'd0)
		else $error("character index did not restart after string end");

endmodule

### dv/modified_utf8_decoder_tb.sv
// ----------------------------------------------------------------------------
// modified_utf8_decoder_tb
// Self-checking bench for the modified UTF-8 decoder. A directed table covers
// the byte-value extremes, every sequence form and the truncation cases.
// Random strings follow, mostly well formed with some noise and some cut
// short. Every character is checked against the table or a built-in decoder model.
// ----------------------------------------------------------------------------
module modified_utf8_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NUM_VECTORS    = 25;
	localparam int unsigned RANDOM_BYTES   = 1700;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned DRAIN_CYCLES   = 6;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam logic [15:0] INDEX_MAX      = 16'hFFFF;

	logic clk;
	logic arst_n;

	mu8_in_if  byte_if ();
	mu8_out_if char_if ();

	modified_utf8_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_if),
		.char_stream (char_if)
	);

	// One row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic [7:0]       byte_val;
		logic             eos;
		logic             typed;
		mu8_pkg::result_t want;
	} vector_t;

	vector_t vectors [NUM_VECTORS];

	// Decoder model state
	logic [2:0]     seq_left;
	mu8_pkg::form_t seq_form;
	logic [20:0]    seq_value;
	logic [2:0]     seq_pos;
	logic [15:0]    char_count;

	// Characters predicted but not yet seen on the output
	mu8_pkg::result_t pending_chars [$];

	// Traffic shaping: bursty is shared by both sides, hold_out stalls the output
	bit bursty;
	bit hold_out;

	int unsigned errors;
	int unsigned bytes_sent;
	int unsigned chars_seen;
	int unsigned strings_seen;
	int unsigned broken_seen;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------
	function automatic logic [2:0] form_bytes(input mu8_pkg::form_t form);
		case (form)
			mu8_pkg::FORM_TWO:   return mu8_pkg::LEN_TWO;
			mu8_pkg::FORM_THREE: return mu8_pkg::LEN_THREE;
			mu8_pkg::FORM_SIX:   return mu8_pkg::LEN_SIX;
			default:             return mu8_pkg::LEN_ONE;
		endcase
	endfunction

	// Payload bits that a continuation byte adds at its position in the sequence.
	// In the six-byte form the second lead (position 2) carries nothing.
	function automatic logic [20:0] tail_bits(input mu8_pkg::form_t form,
			input logic [2:0] pos, input logic [7:0] b);
		if (form == mu8_pkg::FORM_SIX) begin
			case (pos)
				3'd1:    return {17'd0, b[3:0]} << 16;
				3'd3:    return {15'd0, b[5:0]} << 10;
				3'd4:    return {17'd0, b[3:0]} << 6;
				3'd5:    return {15'd0, b[5:0]};
				default: return '0;
			endcase
		end
		if (form == mu8_pkg::FORM_THREE) begin
			if (pos == 3'd1)
				return {15'd0, b[5:0]} << 6;
			if (pos == 3'd2)
				return {15'd0, b[5:0]};
			return '0;
		end
		if (form == mu8_pkg::FORM_TWO && pos == 3'd1)
			return {15'd0, b[5:0]};
		return '0;
	endfunction

	// Advance the model by one byte; emit is set when a character completes
	// or the string ends inside a sequence.
	task automatic decode_byte(input logic [7:0] b, input logic eos, output bit emit,
			output mu8_pkg::result_t ch);
		ch = '0;
		if (seq_left == 3'd0) begin
			if (b == mu8_pkg::LEAD_SIX) begin
				seq_form  = mu8_pkg::FORM_SIX;
				seq_value = mu8_pkg::SUPP_BASE;
			end else if (b >= mu8_pkg::LEAD_THREE_MIN) begin
				seq_form  = mu8_pkg::FORM_THREE;
				seq_value = {5'd0, b[3:0], 12'd0};
			end else if (b >= mu8_pkg::LEAD_TWO_MIN) begin
				seq_form  = mu8_pkg::FORM_TWO;
				seq_value = {10'd0, b[4:0], 6'd0};
			end else begin
				seq_form  = mu8_pkg::FORM_ONE;
				seq_value = {14'd0, b[6:0]};
			end
			seq_left = form_bytes(seq_form) - 3'd1;
			seq_pos  = 3'd1;
		end else begin
			seq_value = seq_value + tail_bits(seq_form, seq_pos, b);
			seq_left  = seq_left - 3'd1;
			seq_pos   = seq_pos + 3'd1;
		end

		emit = (seq_left == 3'd0) || eos;
		if (!emit)
			return;

		ch.code_point = seq_value;
		ch.bytes_used = form_bytes(seq_form);
		ch.char_index = char_count;
		ch.incomplete = (seq_left != 3'd0);
		ch.last       = eos;

		// index restarts with each string, otherwise counts up and sticks at max
		if (eos)
			char_count = '0;
		else if (char_count != INDEX_MAX)
			char_count = char_count + 16'd1;
		seq_left  = '0;
		seq_pos   = '0;
		seq_value = '0;
		seq_form  = mu8_pkg::FORM_ONE;
	endtask

	// ------------------------------------------------------------------------
	// Byte side
	// ------------------------------------------------------------------------
	// Offer one byte and hold it until accepted. valid stays high on return so
	// back-to-back bytes need no deassert.
	task automatic send_byte(input logic [7:0] value, input logic eos, input logic typed,
			input mu8_pkg::result_t want);
		int unsigned gap;
		bit emit;
		mu8_pkg::result_t ch;
		gap = bursty ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid         <= 1'b1;
		byte_if.byte_value    <= value;
		byte_if.end_of_string <= eos;
		@(posedge clk);
		while (!byte_if.ready)
			@(posedge clk);
		decode_byte(value, eos, emit, ch);
		if (typed)
			pending_chars = {pending_chars, want};
		else if (emit)
			pending_chars = {pending_chars, ch};
		bytes_sent++;
	endtask

	// Sender goes quiet until every predicted character has been seen
	task automatic wait_all_chars();
		byte_if.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly proper 10xxxxxx continuation bytes, sometimes anything
	function automatic logic [7:0] tail_byte();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	// One string of random characters; sometimes the last sequence is cut short
	task automatic send_random_string();
		logic [7:0] seq [$];
		logic [7:0] lead;
		int unsigned chars;
		int unsigned c;
		int unsigned pick;
		int unsigned len;
		int unsigned k;
		chars = $urandom_range(1, 12);
		len = 1;
		for (c = 0; c < chars; c++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				lead = 8'($urandom_range(8'h00, 8'h7F));
				len  = 1;
			end else if (pick < 47) begin
				// stray continuation byte in lead position
				lead = 8'($urandom_range(8'h80, 8'hBF));
				len  = 1;
			end else if (pick < 67) begin
				lead = 8'($urandom_range(mu8_pkg::LEAD_TWO_MIN, 8'hDF));
				len  = 2;
			end else if (pick < 85) begin
				do
					lead = 8'($urandom_range(mu8_pkg::LEAD_THREE_MIN, 8'hFF));
				while (lead == mu8_pkg::LEAD_SIX);
				len = 3;
			end else begin
				lead = mu8_pkg::LEAD_SIX;
				len  = 6;
			end
			seq = {seq, lead};
			for (k = 1; k < len; k++)
				seq = {seq, tail_byte()};
		end
		// end the string inside its last sequence
		if (len > 1 && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, len - 1))
				void'(seq.pop_back());
		for (k = 0; k < seq.size(); k++)
			send_byte(seq[k], k == seq.size() - 1, 1'b0, '0);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned row;
		int unsigned random_start;
		int unsigned strings;
		bit paused;

		vectors = '{
			// byte    eos   typed  code_point  len        idx    inc   last
			'{8'h00, 1'b0, 1'b1, '{21'h00000, mu8_pkg::LEN_ONE, 16'd0, 1'b0, 1'b0}},
			'{8'h7F, 1'b0, 1'b1, '{21'h0007F, mu8_pkg::LEN_ONE, 16'd1, 1'b0, 1'b0}},
			// lone continuation bytes decode as one-byte characters
			'{8'h80, 1'b0, 1'b1, '{21'h00000, mu8_pkg::LEN_ONE, 16'd2, 1'b0, 1'b0}},
			'{8'hBF, 1'b0, 1'b1, '{21'h0003F, mu8_pkg::LEN_ONE, 16'd3, 1'b0, 1'b0}},
			// two-byte form, both extremes
			'{8'hC0, 1'b0, 1'b0, '0},
			'{8'h80, 1'b0, 1'b1, '{21'h00000, mu8_pkg::LEN_TWO, 16'd4, 1'b0, 1'b0}},
			'{8'hDF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, '{21'h007FF, mu8_pkg::LEN_TWO, 16'd5, 1'b0, 1'b0}},
			// three-byte form; 0xF0..0xFF leads also take this form
			'{8'hE0, 1'b0, 1'b0, '0},
			'{8'hBF, 1'b0, 1'b0, '0},
			'{8'hBF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h7F, 1'b0, 1'b0, '0},
			// surrogate pair at the top of the code space
			'{8'hED, 1'b0, 1'b0, '0},
			'{8'hAF, 1'b0, 1'b0, '0},
			'{8'hED, 1'b0, 1'b0, '0},
			'{8'hBF, 1'b0, 1'b0, '0},
			'{8'hBF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, '{21'h10FFFF, mu8_pkg::LEN_SIX, 16'd8, 1'b0, 1'b0}},
			'{8'h41, 1'b1, 1'b1, '{21'h00041, mu8_pkg::LEN_ONE, 16'd9, 1'b0, 1'b1}},
			// strings that end inside a sequence, index back at zero
			'{8'hED, 1'b0, 1'b0, '0},
			'{8'hA0, 1'b1, 1'b1, '{21'h10000, mu8_pkg::LEN_SIX, 16'd0, 1'b1, 1'b1}},
			'{8'hE2, 1'b1, 1'b0, '0},
			'{8'hC3, 1'b1, 1'b0, '0}
		};

		byte_if.valid         = 1'b0;
		byte_if.byte_value    = '0;
		byte_if.end_of_string = 1'b0;
		arst_n     = 1'b0;
		bursty     = 1'b1;
		hold_out   = 1'b0;
		seq_left   = '0;
		seq_form   = mu8_pkg::FORM_ONE;
		seq_value  = '0;
		seq_pos    = '0;
		char_count = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < NUM_VECTORS; row++)
			send_byte(vectors[row].byte_val, vectors[row].eos, vectors[row].typed,
				vectors[row].want);
		wait_all_chars();

		// random strings; first the receiver stalls against a steady sender
		bursty       = 1'b0;
		hold_out     = 1'b1;
		random_start = bytes_sent;
		strings      = 0;
		paused       = 1'b0;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			if (strings > 20 && $urandom_range(0, 5) == 0)
				bursty = !bursty;
			if (!paused && bytes_sent - random_start > RANDOM_BYTES / 2) begin
				paused = 1'b1;
				wait_all_chars();
			end
			send_random_string();
			strings++;
		end
		wait_all_chars();

		$display("Checked %0d characters in %0d strings from %0d bytes, %0d cut short.",
			chars_seen, strings_seen, bytes_sent, broken_seen);
		$display("One %0d-cycle output stall applied against a steady sender.",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Character side: random ready, plus one long stall on request
	// ------------------------------------------------------------------------
	initial begin
		int unsigned gap;
		char_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				char_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = bursty ? $urandom_range(0, 19) : 0;
			if (gap != 0) begin
				char_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			char_if.ready <= 1'b1;
			@(posedge clk);
			while (!char_if.valid)
				@(posedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [20:0] want,
			input logic [20:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		mu8_pkg::result_t want;
		if (arst_n && char_if.valid && char_if.ready) begin
			chars_seen++;
			if (char_if.last)
				strings_seen++;
			if (char_if.incomplete)
				broken_seen++;
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected character, expected none, actual 0x%0h",
					$time, char_if.code_point);
			end else begin
				want = pending_chars.pop_front();
				check_field("code_point", want.code_point, char_if.code_point);
				check_field("bytes_used", 21'(want.bytes_used), 21'(char_if.bytes_used));
				check_field("char_index", 21'(want.char_index), 21'(char_if.char_index));
				check_field("incomplete", 21'(want.incomplete), 21'(char_if.incomplete));
				check_field("last", 21'(want.last), 21'(char_if.last));
			end
		end
	end

	// Watchdog: too long without a transaction on either side ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

### sim.f
src/mu8_pkg.sv
src/mu8_in_if.sv
src/mu8_out_if.sv
src/mu8_core.sv
src/modified_utf8_decoder.sv
dv/modified_utf8_decoder_tb.sv
